// ----- rtl/radio_control_frame_responder_defines.svh -----
// ----------------------------------------------------------------------------
// Radio control frame responder assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef RADIO_CONTROL_FRAME_RESPONDER_DEFINES_SVH
`define RADIO_CONTROL_FRAME_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS
// check on every edge outside reset
`define RCFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every edge, reset included
`define RCFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define RCFR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/rcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Radio control frame responder package
// Shared widths, codes and the job word passed from parser to reply side.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned FreqW     = 34;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned BcdDigits = 10;
  localparam int unsigned BcdW      = 4 * BcdDigits;

  localparam int unsigned FreqBytesDefault  = 5;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [ByteW-1:0] Preamble = 8'hFE;
  localparam logic [ByteW-1:0] EndMark  = 8'hFD;
  localparam logic [ByteW-1:0] ReplyCmd = 8'h03;

  localparam logic [FreqW-1:0] FreqMax      = 34'd9999999999;
  localparam logic [FreqW-1:0] FreqReset    = 34'd145000000;
  localparam logic [BcdW-1:0]  FreqBcdReset = 40'h0145000000;
  localparam logic [BcdW-1:0]  FreqBcdMax   = {BcdDigits{4'h9}};

  localparam logic [ByteW-1:0] ModeReset    = 8'd1;
  localparam logic [ByteW-1:0] SquelchReset = 8'd1;

  localparam logic [ByteW-1:0] SetFreqCodeReset = 8'd5;
  localparam logic [ByteW-1:0] GetFreqCodeReset = 8'd3;
  localparam logic [ByteW-1:0] SetModeCodeReset = 8'd6;
  localparam logic [ByteW-1:0] SetSqlCodeReset  = 8'd20;

  typedef enum logic [KindW-1:0] {
    KIND_TX      = 2'd0,
    KIND_FREQ    = 2'd1,
    KIND_MODE    = 2'd2,
    KIND_SQUELCH = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SET_FREQ = 2'd0,
    REG_GET_FREQ = 2'd1,
    REG_SET_MODE = 2'd2,
    REG_SET_SQL  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_PRE1 = 3'd0,
    PH_PRE2 = 3'd1,
    PH_TO   = 3'd2,
    PH_FROM = 3'd3,
    PH_CMD  = 3'd4,
    PH_FREQ = 3'd5,
    PH_ONE  = 3'd6,
    PH_END  = 3'd7
  } phase_e;

  // One queued job: an event word or a whole reply frame
  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  target;
    logic [ByteW-1:0]  source;
    logic [FreqW-1:0]  frequency;
    logic [BcdW-1:0]   freq_bcd;
    logic [ByteW-1:0]  mode;
    logic [ByteW-1:0]  squelch;
  } job_t;

endpackage

`default_nettype wire

// ----- rtl/rcfr_byte_if.sv -----
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one received serial byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcfr_byte_if
  import rcfr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/rcfr_result_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one transmit byte or change event per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcfr_result_if
  import rcfr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] tx_byte;
  logic [FreqW-1:0] frequency;
  logic [ByteW-1:0] mode;
  logic [ByteW-1:0] squelch;
  logic             last;

  modport source (output valid, output kind, output tx_byte, output frequency,
                  output mode, output squelch, output last, input ready);
  modport sink   (input valid, input kind, input tx_byte, input frequency,
                  input mode, input squelch, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/rcfr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcfr_cfg_if
  import rcfr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rcfr_parser.sv -----
// ----------------------------------------------------------------------------
// Frame parser
// Takes one byte a cycle unless the job queue is full, tracks the frame, keeps
// stored values and command codes, and pushes one job per byte with results.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfr_parser
  import rcfr_pkg::*;
#(
  parameter int unsigned FREQ_BYTES = FreqBytesDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  rcfr_byte_if.sink   rx_i,
  rcfr_cfg_if.sink    cfg_i,
  input  wire         full_i,
  output logic        push_o,
  output job_t        job_o
);

  localparam int unsigned CntW = (FREQ_BYTES > 1) ? $clog2(FREQ_BYTES) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(FREQ_BYTES - 1);
  localparam int unsigned ProdW = FreqW + 7;

  phase_e             phase_q, phase_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [ByteW-1:0]   cmd_q, cmd_d;
  logic [ByteW-1:0]   tgt_q, tgt_d;
  logic [ByteW-1:0]   src_q, src_d;
  logic [FreqW-1:0]   acc_q, acc_d;
  logic [BcdW-1:0]    acc_bcd_q, acc_bcd_d;
  logic [FreqW-1:0]   freq_q, freq_d;
  logic [BcdW-1:0]    freq_bcd_q, freq_bcd_d;
  logic [ByteW-1:0]   mode_q, mode_d;
  logic [ByteW-1:0]   squelch_q, squelch_d;
  logic [ByteW-1:0]   set_freq_code_q, get_freq_code_q, set_mode_code_q, set_sql_code_q;

  logic               accept;
  logic [ByteW-1:0]   b;
  logic [3:0]         hi, lo;
  logic [ByteW-1:0]   pair_val;
  logic [ProdW-1:0]   prod;
  logic [FreqW-1:0]   acc_next;
  logic [BcdW-1:0]    bcd_next;
  kind_e              job_kind;
  logic               is_set_freq, is_get_freq, is_one_byte;

  assign accept     = rx_i.valid && rx_i.ready;
  assign rx_i.ready = !full_i;
  assign cfg_i.ready = 1'b1;
  assign b  = rx_i.rx_byte;
  assign hi = b[7:4];
  assign lo = b[3:0];

  assign is_set_freq = (b == set_freq_code_q);
  assign is_get_freq = (b == get_freq_code_q);
  assign is_one_byte = (b == set_mode_code_q) || (b == set_sql_code_q);

  // binary digit-pair step: acc * 100 + hi * 10 + lo, saturated
  always_comb begin
    pair_val = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
    prod = ({7'd0, acc_q} << 6) + ({7'd0, acc_q} << 5) + ({7'd0, acc_q} << 2)
         + ProdW'(pair_val);
    acc_next = (prod > ProdW'(FreqMax)) ? FreqMax : prod[FreqW-1:0];
  end

  // decimal shadow of the same step, so replies need no conversion
  always_comb begin
    logic [3:0]      d0, d1, s;
    logic [4:0]      t1;
    logic            c1, c2, carry, ovf;
    logic [BcdW-1:0] shifted;
    c1 = (lo > 4'd9);
    d0 = c1 ? (lo - 4'd10) : lo;
    t1 = {1'b0, hi} + {4'd0, c1};
    c2 = (t1 > 5'd9);
    d1 = c2 ? 4'(t1 - 5'd10) : t1[3:0];
    shifted  = {acc_bcd_q[BcdW-9:0], d1, d0};
    bcd_next = shifted;
    carry    = c2;
    for (int k = 2; k < BcdDigits; k++) begin
      s = shifted[4*k +: 4];
      if (carry) begin
        bcd_next[4*k +: 4] = (s == 4'd9) ? 4'd0 : (s + 4'd1);
      end
      carry = carry && (s == 4'd9);
    end
    ovf = (acc_bcd_q[BcdW-1 -: 8] != 8'd0) || carry;
    if (ovf) begin
      bcd_next = FreqBcdMax;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_PRE1: if (b == Preamble) phase_d = PH_PRE2;
        PH_PRE2: phase_d = (b == Preamble) ? PH_TO : PH_PRE1;
        PH_TO:   phase_d = PH_FROM;
        PH_FROM: phase_d = PH_CMD;
        PH_CMD: begin
          priority if (is_set_freq) phase_d = PH_FREQ;
          else if (is_get_freq)     phase_d = PH_END;
          else if (is_one_byte)     phase_d = PH_ONE;
          else                      phase_d = PH_END;
        end
        PH_FREQ: if (cnt_q == LastCnt) phase_d = PH_END;
        PH_ONE:  phase_d = PH_END;
        PH_END:  phase_d = PH_PRE1;
      endcase
    end
  end

  // datapath and job push
  always_comb begin
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    tgt_d      = tgt_q;
    src_d      = src_q;
    acc_d      = acc_q;
    acc_bcd_d  = acc_bcd_q;
    freq_d     = freq_q;
    freq_bcd_d = freq_bcd_q;
    mode_d     = mode_q;
    squelch_d  = squelch_q;
    push_o     = 1'b0;
    job_kind   = KIND_TX;
    if (accept) begin
      unique case (phase_q)
        PH_TO:   tgt_d = b;
        PH_FROM: src_d = b;
        PH_CMD: begin
          cmd_d = b;
          if (is_set_freq) begin
            cnt_d     = '0;
            acc_d     = '0;
            acc_bcd_d = '0;
          end else if (is_get_freq) begin
            push_o   = 1'b1;
            job_kind = KIND_TX;
          end
        end
        PH_FREQ: begin
          acc_d     = acc_next;
          acc_bcd_d = bcd_next;
          if (cnt_q == LastCnt) begin
            cnt_d      = '0;
            freq_d     = acc_next;
            freq_bcd_d = bcd_next;
            push_o     = 1'b1;
            job_kind   = KIND_FREQ;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        PH_ONE: begin
          push_o = 1'b1;
          if (cmd_q == set_mode_code_q) begin
            mode_d   = b;
            job_kind = KIND_MODE;
          end else begin
            squelch_d = b;
            job_kind  = KIND_SQUELCH;
          end
        end
        default: ;
      endcase
    end
    job_o.kind      = job_kind;
    job_o.target    = tgt_q;
    job_o.source    = src_q;
    job_o.frequency = freq_d;
    job_o.freq_bcd  = freq_bcd_d;
    job_o.mode      = mode_d;
    job_o.squelch   = squelch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_PRE1;
      cnt_q      <= '0;
      cmd_q      <= '0;
      tgt_q      <= '0;
      src_q      <= '0;
      acc_q      <= '0;
      acc_bcd_q  <= '0;
      freq_q     <= FreqReset;
      freq_bcd_q <= FreqBcdReset;
      mode_q     <= ModeReset;
      squelch_q  <= SquelchReset;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      cmd_q      <= cmd_d;
      tgt_q      <= tgt_d;
      src_q      <= src_d;
      acc_q      <= acc_d;
      acc_bcd_q  <= acc_bcd_d;
      freq_q     <= freq_d;
      freq_bcd_q <= freq_bcd_d;
      mode_q     <= mode_d;
      squelch_q  <= squelch_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_freq_code_q <= SetFreqCodeReset;
      get_freq_code_q <= GetFreqCodeReset;
      set_mode_code_q <= SetModeCodeReset;
      set_sql_code_q  <= SetSqlCodeReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_SET_FREQ: set_freq_code_q <= cfg_i.data;
        REG_GET_FREQ: get_freq_code_q <= cfg_i.data;
        REG_SET_MODE: set_mode_code_q <= cfg_i.data;
        REG_SET_SQL:  set_sql_code_q  <= cfg_i.data;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rcfr_job_fifo.sv -----
// ----------------------------------------------------------------------------
// Job queue
// Short register queue between the parser and the reply generator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radio_control_frame_responder_defines.svh"

module rcfr_job_fifo
  import rcfr_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  wire job_t  job_i,
  output logic       full_o,
  input  wire        pop_i,
  output job_t       head_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  job_t            entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  `RCFR_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(DEPTH), "job queue count overrun")
  `RCFR_ASSERT(a_no_push_full, clk_i, rst_ni, full_o |-> !push_i, "push into full job queue")
  `RCFR_ASSERT(a_no_pop_empty, clk_i, rst_ni, empty_o |-> !pop_i, "pop from empty job queue")
  `RCFR_ASSERT(a_count_up, clk_i, rst_ni,
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1), "job queue count lost a push")

endmodule

`default_nettype wire

// ----- rtl/rcfr_reply_gen.sv -----
// ----------------------------------------------------------------------------
// Reply generator
// Expands the head job into result words through one output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radio_control_frame_responder_defines.svh"

module rcfr_reply_gen
  import rcfr_pkg::*;
#(
  parameter int unsigned FREQ_BYTES = FreqBytesDefault
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire job_t      head_i,
  input  wire            empty_i,
  output logic           pop_o,
  rcfr_result_if.source  tx_o
);

  localparam int unsigned WordCnt = FREQ_BYTES + 6;
  localparam int unsigned CntW    = $clog2(WordCnt);
  localparam int unsigned PadW    = (8 * FREQ_BYTES > BcdW) ? 8 * FREQ_BYTES : BcdW;
  localparam logic [CntW-1:0] IdxSrc   = CntW'(2);
  localparam logic [CntW-1:0] IdxTgt   = CntW'(3);
  localparam logic [CntW-1:0] IdxCmd   = CntW'(4);
  localparam logic [CntW-1:0] IdxFirst = CntW'(5);
  localparam logic [CntW-1:0] IdxLast  = CntW'(WordCnt - 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             valid_q, valid_d;
  kind_e            kind_q;
  logic [ByteW-1:0] tx_byte_q, byte_sel;
  logic [FreqW-1:0] freq_q;
  logic [ByteW-1:0] mode_q, squelch_q;
  logic             last_q;
  logic             load, final_word;
  logic [PadW-1:0]  bcd_pad;

  assign load       = !valid_q || tx_o.ready;
  assign final_word = (head_i.kind != KIND_TX) || (cnt_q == IdxLast);
  assign pop_o      = load && !empty_i && final_word;
  assign bcd_pad    = PadW'(head_i.freq_bcd);

  // pick the reply byte at the current word position
  always_comb begin
    byte_sel = EndMark;
    priority if (cnt_q < IdxSrc) byte_sel = Preamble;
    else if (cnt_q == IdxSrc)    byte_sel = head_i.source;
    else if (cnt_q == IdxTgt)    byte_sel = head_i.target;
    else if (cnt_q == IdxCmd)    byte_sel = ReplyCmd;
    else if (cnt_q == IdxLast)   byte_sel = EndMark;
    else begin
      for (int i = 0; i < FREQ_BYTES; i++) begin
        if (cnt_q == IdxFirst + CntW'(i)) begin
          byte_sel = bcd_pad[8 * (FREQ_BYTES - 1 - i) +: 8];
        end
      end
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        cnt_d = final_word ? '0 : cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      kind_q    <= head_i.kind;
      tx_byte_q <= (head_i.kind == KIND_TX) ? byte_sel : '0;
      freq_q    <= head_i.frequency;
      mode_q    <= head_i.mode;
      squelch_q <= head_i.squelch;
      last_q    <= final_word;
    end
  end

  assign tx_o.valid     = valid_q;
  assign tx_o.kind      = kind_q;
  assign tx_o.tx_byte   = tx_byte_q;
  assign tx_o.frequency = freq_q;
  assign tx_o.mode      = mode_q;
  assign tx_o.squelch   = squelch_q;
  assign tx_o.last      = last_q;

  `RCFR_ASSERT(a_idle_cnt, clk_i, rst_ni, empty_i |-> (cnt_q == '0), "word count left mid-frame")
  `RCFR_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= IdxLast, "word count past frame end")
  `RCFR_ASSERT(a_pop_last, clk_i, rst_ni, pop_o |=> (tx_o.valid && tx_o.last),
    "job retired without a final word")

endmodule

`default_nettype wire

// ----- rtl/radio_control_frame_responder.sv -----
// ----------------------------------------------------------------------------
// Radio control frame responder
// Parses received command frames, keeps frequency, mode and squelch, and
// answers frequency requests with a reply frame, one result word at a time.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle; the input stalls only while the
//   job queue (QUEUE_DEPTH entries) is full.
// A byte's job goes through the job queue to the single output register of
//   the reply generator. A reply frame is FREQ_BYTES + 6 words on the output
//   port, one word per cycle while the output is ready.
// Reset: asynchronous, active low; codes, stored values and parse state
//   return to their defaults at once, no clearing pass.
`default_nettype none

module radio_control_frame_responder
  import rcfr_pkg::*;
#(
  parameter int unsigned FREQ_BYTES  = FreqBytesDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  rcfr_byte_if.sink      rx_i,
  rcfr_cfg_if.sink       cfg_i,
  rcfr_result_if.source  tx_o
);

  // front to queue
  logic push;
  job_t job;
  logic full;

  // queue to back
  logic pop;
  job_t head;
  logic empty;

  // Front: track the frame, update stored values, push one job for each
  // byte that causes results (an event or a whole reply frame).
  rcfr_parser #(
    .FREQ_BYTES(FREQ_BYTES)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_i),
    .cfg_i (cfg_i),
    .full_i(full),
    .push_o(push),
    .job_o (job)
  );

  // Hold jobs so the parser keeps taking bytes while a reply drains.
  rcfr_job_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty)
  );

  // Back: expand the head job into result words, retire it on its last word.
  rcfr_reply_gen #(
    .FREQ_BYTES(FREQ_BYTES)
  ) u_reply_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .empty_i(empty),
    .pop_o  (pop),
    .tx_o   (tx_o)
  );

endmodule

`default_nettype wire
